FILE: sv/csbr_pkg.sv
// Package for the clock-sweep buffer replacement block.
// Types, constants and status codes shared by all modules.
package csbr_pkg;
    localparam int FRAMES_DEF = 64;
    localparam int PAGE_W     = 32;
    localparam int USE_W      = 4;
    localparam int IDX_OUT_W  = 6;
    localparam logic [USE_W-1:0] MAX_USAGE_RST = 4'd5;

    typedef enum logic [1:0] {
        OP_FETCH = 2'd0,
        OP_PIN   = 2'd1,
        OP_UNPIN = 2'd2,
        OP_NOP   = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_MISS_NEW = 3'd1,
        ST_MISS_EV  = 3'd2,
        ST_ALL_PIN  = 3'd3,
        ST_PIN_DONE = 3'd4,
        ST_ABSENT   = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_LAST,
        S_SWEEP,
        S_SWEEP_WAIT,
        S_OUT
    } state_t;
endpackage

FILE: sv/csbr_frame_mem.sv
// Frame table: page memory plus per-frame usage memory.
// Both memories have registered reads; valid and pin bits are flops.
module csbr_frame_mem #(
    parameter int FRAMES = csbr_pkg::FRAMES_DEF,
    parameter int IW = $clog2(FRAMES)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [IW-1:0]               rd_addr,
    output logic [csbr_pkg::PAGE_W-1:0] rd_page,
    output logic [csbr_pkg::USE_W-1:0]  rd_usage,
    output logic                        rd_valid,
    output logic                        rd_pinned,
    input  logic                        pg_we,
    input  logic [IW-1:0]               pg_addr,
    input  logic [csbr_pkg::PAGE_W-1:0] pg_data,
    input  logic                        us_we,
    input  logic [IW-1:0]               us_addr,
    input  logic [csbr_pkg::USE_W-1:0]  us_data,
    input  logic                        pin_we,
    input  logic [IW-1:0]               pin_addr,
    input  logic                        pin_data,
    output logic [FRAMES-1:0]           pinned_all
);
    import csbr_pkg::*;

    logic [PAGE_W-1:0] page_mem [FRAMES];
    logic [USE_W-1:0]  use_mem  [FRAMES];
    logic [FRAMES-1:0] valid_reg;
    logic [FRAMES-1:0] pin_reg;
    logic [FRAMES-1:0] use_ok_reg;
    logic [USE_W-1:0]  use_q;
    logic              use_ok_q;

    always_ff @(posedge clk)
    begin
        if (pg_we)
        begin
            page_mem[pg_addr] <= pg_data;
        end
        if (us_we)
        begin
            use_mem[us_addr] <= us_data;
        end
        rd_page <= page_mem[rd_addr];
        use_q   <= use_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            pin_reg    <= '0;
            use_ok_reg <= '0;
            rd_valid   <= 1'b0;
            rd_pinned  <= 1'b0;
            use_ok_q   <= 1'b0;
        end
        else
        begin
            if (pg_we)
            begin
                valid_reg[pg_addr] <= 1'b1;
            end
            if (us_we)
            begin
                use_ok_reg[us_addr] <= 1'b1;
            end
            if (pin_we)
            begin
                pin_reg[pin_addr] <= pin_data;
            end
            rd_valid  <= valid_reg[rd_addr];
            rd_pinned <= pin_reg[rd_addr];
            use_ok_q  <= use_ok_reg[rd_addr];
        end
    end

    assign rd_usage   = use_ok_q ? use_q : '0;
    assign pinned_all = pin_reg;
endmodule

FILE: sv/csbr_ctrl.sv
// Request sequencer: lookup scan, clock sweep and result register.
// Depends on csbr_pkg and drives the csbr_frame_mem ports.
module csbr_ctrl #(
    parameter int FRAMES = csbr_pkg::FRAMES_DEF,
    parameter int IW = $clog2(FRAMES)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    opcode,
    input  logic [csbr_pkg::PAGE_W-1:0]   page_number,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    status,
    output logic [csbr_pkg::IDX_OUT_W-1:0] frame_index,
    output logic [csbr_pkg::PAGE_W-1:0]   evicted_page,
    output logic [csbr_pkg::USE_W-1:0]    usage_after,
    input  logic [csbr_pkg::USE_W-1:0]    max_usage,
    output logic [IW-1:0]                 rd_addr,
    input  logic [csbr_pkg::PAGE_W-1:0]   rd_page,
    input  logic [csbr_pkg::USE_W-1:0]    rd_usage,
    input  logic                          rd_valid,
    input  logic                          rd_pinned,
    output logic                          pg_we,
    output logic [IW-1:0]                 pg_addr,
    output logic [csbr_pkg::PAGE_W-1:0]   pg_data,
    output logic                          us_we,
    output logic [IW-1:0]                 us_addr,
    output logic [csbr_pkg::USE_W-1:0]    us_data,
    output logic                          pin_we,
    output logic [IW-1:0]                 pin_addr,
    output logic                          pin_data,
    input  logic [FRAMES-1:0]             pinned_all
);
    import csbr_pkg::*;

    localparam logic [IW-1:0] LAST = IW'(FRAMES - 1);

    state_t            state_reg, state_next;
    logic [1:0]        op_reg, op_next;
    logic [PAGE_W-1:0] page_reg, page_next;
    logic [IW-1:0]     scan_reg, scan_next;
    logic [IW-1:0]     prev_reg, prev_next;
    logic [IW-1:0]     hand_reg, hand_next;
    logic [2:0]        st_reg, st_next;
    logic [IW-1:0]     fidx_reg, fidx_next;
    logic [PAGE_W-1:0] ev_reg, ev_next;
    logic [USE_W-1:0]  use_reg, use_next;
    logic [USE_W:0]    inc;

    assign inc = {1'b0, rd_usage} + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            hand_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            hand_reg  <= hand_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        page_reg <= page_next;
        scan_reg <= scan_next;
        prev_reg <= prev_next;
        st_reg   <= st_next;
        fidx_reg <= fidx_next;
        ev_reg   <= ev_next;
        use_reg  <= use_next;
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        page_next  = page_reg;
        scan_next  = scan_reg;
        prev_next  = prev_reg;
        hand_next  = hand_reg;
        st_next    = st_reg;
        fidx_next  = fidx_reg;
        ev_next    = ev_reg;
        use_next   = use_reg;
        in_ready   = 1'b0;
        rd_addr    = scan_reg;
        pg_we      = 1'b0;
        pg_addr    = prev_reg;
        pg_data    = page_reg;
        us_we      = 1'b0;
        us_addr    = prev_reg;
        us_data    = '0;
        pin_we     = 1'b0;
        pin_addr   = prev_reg;
        pin_data   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                rd_addr  = '0;
                if (in_valid)
                begin
                    op_next   = opcode;
                    page_next = page_number;
                    prev_next = '0;
                    scan_next = (FRAMES > 1) ? IW'(1) : '0;
                    st_next   = ST_ABSENT;
                    fidx_next = '0;
                    ev_next   = '0;
                    use_next  = '0;
                    state_next = (opcode == OP_NOP) ? S_OUT : S_SCAN;
                end
            end
            S_SCAN, S_SCAN_LAST:
            begin
                rd_addr = scan_reg;
                if (rd_valid && rd_page == page_reg)
                begin
                    fidx_next = prev_reg;
                    if (op_reg == OP_FETCH)
                    begin
                        st_next  = ST_HIT;
                        use_next = (inc > {1'b0, max_usage}) ? max_usage : inc[USE_W-1:0];
                        us_we    = 1'b1;
                        us_data  = use_next;
                    end
                    else
                    begin
                        st_next  = ST_PIN_DONE;
                        use_next = rd_usage;
                        pin_we   = 1'b1;
                        pin_data = (op_reg == OP_PIN);
                    end
                    state_next = S_OUT;
                end
                else if (state_reg == S_SCAN_LAST)
                begin
                    if (op_reg != OP_FETCH)
                    begin
                        state_next = S_OUT;
                    end
                    else if (&pinned_all)
                    begin
                        st_next    = ST_ALL_PIN;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        rd_addr    = hand_reg;
                        state_next = S_SWEEP;
                    end
                end
                else
                begin
                    prev_next = scan_reg;
                    scan_next = (scan_reg == LAST) ? '0 : scan_reg + 1'b1;
                    if (scan_reg == LAST)
                    begin
                        state_next = S_SCAN_LAST;
                    end
                end
            end
            S_SWEEP:
            begin
                // data at rd for hand_reg available now
                if (!rd_pinned && rd_usage == '0)
                begin
                    st_next   = rd_valid ? ST_MISS_EV : ST_MISS_NEW;
                    ev_next   = rd_valid ? rd_page : '0;
                    fidx_next = hand_reg;
                    use_next  = USE_W'(1);
                    pg_we     = 1'b1;
                    pg_addr   = hand_reg;
                    us_we     = 1'b1;
                    us_addr   = hand_reg;
                    us_data   = USE_W'(1);
                    pin_we    = 1'b1;
                    pin_addr  = hand_reg;
                    pin_data  = 1'b0;
                    hand_next = (hand_reg == LAST) ? '0 : hand_reg + 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    if (!rd_pinned)
                    begin
                        us_we   = 1'b1;
                        us_addr = hand_reg;
                        us_data = rd_usage - 1'b1;
                    end
                    hand_next  = (hand_reg == LAST) ? '0 : hand_reg + 1'b1;
                    rd_addr    = hand_next;
                    state_next = S_SWEEP;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid    = (state_reg == S_OUT);
    assign status       = st_reg;
    assign frame_index  = IDX_OUT_W'(fidx_reg);
    assign evicted_page = ev_reg;
    assign usage_after  = use_reg;

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == S_IDLE)
        else $error("ready outside idle");
    a_hand_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |=> hand_reg == $past(hand_reg))
        else $error("hand moved while idle");
    a_out_one: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready) |=> !out_valid)
        else $error("result repeated");
endmodule

FILE: sv/clock_sweep_buffer_replacement.sv
// Clock-sweep buffer replacement, top level.
// A hit or pin change answers once the lookup scan reaches its frame; an absent page
// answers after the full scan, a miss after the full scan and a clock sweep; a no-op
// goes straight to the result. The lookup scan reads one frame per cycle.
// One transaction at a time; the next input is taken in the cycle after the result.
// Reset (rst_n, async) clears valid, pin and usage marks, hand and max_usage=5.
module clock_sweep_buffer_replacement #(
    parameter int FRAMES = csbr_pkg::FRAMES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [31:0] page_number,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [5:0]  frame_index,
    output logic [31:0] evicted_page,
    output logic [3:0]  usage_after,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_data
);
    import csbr_pkg::*;

    localparam int IW = $clog2(FRAMES);

    logic [USE_W-1:0]  max_usage_reg;
    logic [IW-1:0]     rd_addr, pg_addr, us_addr, pin_addr;
    logic [PAGE_W-1:0] rd_page, pg_data;
    logic [USE_W-1:0]  rd_usage, us_data;
    logic              rd_valid, rd_pinned, pg_we, us_we, pin_we, pin_data;
    logic [FRAMES-1:0] pinned_all;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_usage_reg <= MAX_USAGE_RST;
        end
        else if (cfg_we)
        begin
            max_usage_reg <= cfg_data;
        end
    end

    csbr_frame_mem #(.FRAMES(FRAMES), .IW(IW)) u_mem (
        .clk(clk), .rst_n(rst_n), .rd_addr(rd_addr), .rd_page(rd_page),
        .rd_usage(rd_usage), .rd_valid(rd_valid), .rd_pinned(rd_pinned),
        .pg_we(pg_we), .pg_addr(pg_addr), .pg_data(pg_data),
        .us_we(us_we), .us_addr(us_addr), .us_data(us_data),
        .pin_we(pin_we), .pin_addr(pin_addr), .pin_data(pin_data),
        .pinned_all(pinned_all)
    );

    csbr_ctrl #(.FRAMES(FRAMES), .IW(IW)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .page_number(page_number), .out_valid(out_valid),
        .out_ready(out_ready), .status(status), .frame_index(frame_index),
        .evicted_page(evicted_page), .usage_after(usage_after),
        .max_usage(max_usage_reg), .rd_addr(rd_addr), .rd_page(rd_page),
        .rd_usage(rd_usage), .rd_valid(rd_valid), .rd_pinned(rd_pinned),
        .pg_we(pg_we), .pg_addr(pg_addr), .pg_data(pg_data),
        .us_we(us_we), .us_addr(us_addr), .us_data(us_data),
        .pin_we(pin_we), .pin_addr(pin_addr), .pin_data(pin_data),
        .pinned_all(pinned_all)
    );
endmodule
